### sv/periodic_timer_table_unit_macros.svh
// Assertion macros for the periodic timer table unit.
// Included by the top level only; relies on a clock named clk and a reset named rst.
`ifndef PERIODIC_TIMER_TABLE_UNIT_MACROS_SVH
`define PERIODIC_TIMER_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define PTTU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pttu assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define PTTU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pttu assertion failed");
`else
`define PTTU_ASSERT_SAME(label, ante, cons)
`define PTTU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### sv/pttu_pkg.sv
// Package for the periodic timer table unit: beat types, codes and fixed constants.
// No dependencies; used by every module of the unit.
`default_nettype none
package pttu_pkg;

  // Request kinds; the last one is ignored by the unit.
  localparam logic [1:0] K_TICK = 2'd0;
  localparam logic [1:0] K_SET  = 2'd1;
  localparam logic [1:0] K_KILL = 2'd2;
  localparam logic [1:0] K_NONE = 2'd3;

  // Result kinds.
  localparam logic RK_STATUS = 1'b0;
  localparam logic RK_FIRE   = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // Reset value of the minimum interval register.
  localparam logic [31:0] MIN_INTERVAL_RST = 32'd100;

  // At most this many timers fire on one tick.
  localparam int FIRE_CAP = 16;
  localparam int FIRE_W   = $clog2(FIRE_CAP + 1);

  // One input beat.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tmr_id;
    logic [31:0] period_ms;
    logic [47:0] now_ms;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic        result_kind;
    logic [31:0] fired_id;
    logic [1:0]  status;
    logic        last;
  } result_t;

  // Write command to the slot file.
  typedef struct packed {
    logic        entry_we;  // store id, period and last-fire, mark valid
    logic        lf_we;     // update last-fire only
    logic        clr_we;    // free the slot at the clear address
    logic [31:0] id;
    logic [31:0] period;
    logic [47:0] last_fire;
  } slot_wr_t;

  // Registered outcome of the due check.
  typedef struct packed {
    logic        back;  // time ran backwards
    logic        due;   // elapsed time reached the period
    logic [47:0] sum;   // last-fire plus period, modulo 2^48
  } due_res_t;

endpackage
`default_nettype wire

### sv/pttu_slot_file.sv
// Slot storage of the periodic timer table unit: valid bits, ids, periods, last-fire times.
// Depends on pttu_pkg for the write command type.
`default_nettype none
module pttu_slot_file #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pttu_pkg::slot_wr_t  wr,
  input  wire logic [IDX_W-1:0]    waddr,
  input  wire logic [IDX_W-1:0]    clr_addr,
  input  wire logic [IDX_W-1:0]    raddr,
  output logic                     rd_valid,
  output logic [31:0]              rd_id,
  output logic [31:0]              rd_period,
  output logic [47:0]              rd_last_fire
);
  import pttu_pkg::*;

  logic [DEPTH-1:0] valid;
  logic [31:0]      id_mem     [DEPTH];
  logic [31:0]      period_mem [DEPTH];
  logic [47:0]      lf_mem     [DEPTH];

  // Valid bits; a store to the same slot as a clear wins.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (wr.clr_we) begin
        valid[clr_addr] <= 1'b0;
      end
      if (wr.entry_we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  // Payload fields carry no reset; they are only read while valid.
  always_ff @(posedge clk) begin
    if (wr.entry_we) begin
      id_mem[waddr]     <= wr.id;
      period_mem[waddr] <= wr.period;
    end
    if (wr.entry_we || wr.lf_we) begin
      lf_mem[waddr] <= wr.last_fire;
    end
  end

  // Single read port at the scan index.
  assign rd_valid     = valid[raddr];
  assign rd_id        = id_mem[raddr];
  assign rd_period    = period_mem[raddr];
  assign rd_last_fire = lf_mem[raddr];

endmodule
`default_nettype wire

### sv/pttu_due_unit.sv
// Shared due-check unit: elapsed-time subtract and next-fire add, then a period compare.
// Depends on pttu_pkg for the result type.
`default_nettype none
module pttu_due_unit (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic [47:0]        last_fire,
  input  wire logic [31:0]        period,
  input  wire logic [47:0]        now,
  output pttu_pkg::due_res_t      res
);
  import pttu_pkg::*;

  logic        back;
  logic [47:0] diff;
  logic [47:0] sum;
  logic [31:0] period_q;

  // First step, registered: subtract with borrow and the advanced last-fire time.
  always_ff @(posedge clk) begin
    if (load) begin
      {back, diff} <= {1'b0, now} - {1'b0, last_fire};
      sum          <= last_fire + {16'd0, period};
      period_q     <= period;
    end
  end

  // Second step, combinational: compare the elapsed time with the period.
  assign res.back = back;
  assign res.due  = !back && (diff >= {16'd0, period_q});
  assign res.sum  = sum;

endmodule
`default_nettype wire

### sv/periodic_timer_table_unit.sv
// Top level of the periodic timer table unit: sequencer, config register and result register.
// Depends on pttu_pkg, pttu_slot_file, pttu_due_unit and the macros header.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------
//   request  | start, busy         | cmd   (pttu_pkg::cmd_t)
//   result   | result_valid        | result (pttu_pkg::result_t)
//   config   | cfg_we              | cfg_data (min_interval)
//
// A set checks its interval, then scans every slot, one scan step per slot, and commits;
// a refused set ends at the check. A kill scans and commits alike; an ignored kind leaves the unit idle.
// A tick visits every slot in turn and passes each valid one through the shared due unit,
// so it lasts longer the more slots are valid; it ends early once the fire cap is reached.
// A fire beat is sent when the next fire is found, so beats of a tick never come back to back.
// Reset clears all slots and sets min_interval to 100; no clearing pass.
// Each result beat is held one cycle; the receiver cannot stall.
`default_nettype none
`include "periodic_timer_table_unit_macros.svh"
module periodic_timer_table_unit #(
  parameter int MAX_TIMERS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire pttu_pkg::cmd_t    cmd,
  output logic                   result_valid,
  output pttu_pkg::result_t      result,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_data
);
  import pttu_pkg::*;

  localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W = $clog2(MAX_TIMERS + 1);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_TIMERS - 1);
  localparam logic [CNT_W-1:0] END_IDX  = CNT_W'(MAX_TIMERS);
  localparam logic [FIRE_W-1:0] FIRE_MAX = FIRE_W'(FIRE_CAP);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CHECK    = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_COMMIT   = 3'd3;
  localparam logic [2:0] S_TICK_A   = 3'd4;
  localparam logic [2:0] S_TICK_B   = 3'd5;
  localparam logic [2:0] S_TICK_END = 3'd6;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [FIRE_W-1:0] fires, fires_next;
  cmd_t              req, req_next;
  logic              match_found, match_found_next;
  logic [IDX_W-1:0]  match_idx, match_idx_next;
  logic              free_found, free_found_next;
  logic [IDX_W-1:0]  free_idx, free_idx_next;
  logic              pend, pend_next;
  logic [31:0]       pend_id, pend_id_next;
  logic              result_valid_next;
  result_t           result_next;
  logic [31:0]       min_interval;

  slot_wr_t          wr;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_valid;
  logic [31:0]       rd_id;
  logic [31:0]       rd_period;
  logic [47:0]       rd_last_fire;
  logic              due_load;
  due_res_t          due;

  assign rd_idx = idx[IDX_W-1:0];
  assign busy   = (state != S_IDLE);

  pttu_slot_file #(
    .DEPTH (MAX_TIMERS),
    .IDX_W (IDX_W)
  ) u_slots (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .waddr        (waddr),
    .clr_addr     (match_idx),
    .raddr        (rd_idx),
    .rd_valid     (rd_valid),
    .rd_id        (rd_id),
    .rd_period    (rd_period),
    .rd_last_fire (rd_last_fire)
  );

  pttu_due_unit u_due (
    .clk       (clk),
    .load      (due_load),
    .last_fire (rd_last_fire),
    .period    (rd_period),
    .now       (req.now_ms),
    .res       (due)
  );

  // Sequencer: one slot per step, results sent through the output register.
  always_comb begin
    state_next        = state;
    idx_next          = idx;
    fires_next        = fires;
    req_next          = req;
    match_found_next  = match_found;
    match_idx_next    = match_idx;
    free_found_next   = free_found;
    free_idx_next     = free_idx;
    pend_next         = pend;
    pend_id_next      = pend_id;
    result_valid_next = 1'b0;
    result_next       = result;
    due_load          = 1'b0;
    waddr             = rd_idx;
    wr.entry_we       = 1'b0;
    wr.lf_we          = 1'b0;
    wr.clr_we         = 1'b0;
    wr.id             = req.tmr_id;
    wr.period         = req.period_ms;
    wr.last_fire      = req.now_ms;

    case (state)
      S_IDLE: begin
        if (start) begin
          req_next         = cmd;
          idx_next         = '0;
          fires_next       = '0;
          pend_next        = 1'b0;
          match_found_next = 1'b0;
          free_found_next  = 1'b0;
          case (cmd.kind)
            K_TICK:  state_next = S_TICK_A;
            K_SET:   state_next = S_CHECK;
            K_KILL:  state_next = S_SCAN;
            default: state_next = S_IDLE;
          endcase
        end
      end

      S_CHECK: begin
        if (req.period_ms < min_interval) begin
          result_valid_next       = 1'b1;
          result_next.result_kind = RK_STATUS;
          result_next.fired_id    = req.tmr_id;
          result_next.status      = ST_REJECT;
          result_next.last        = 1'b1;
          state_next              = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end

      // Find the lowest slot holding the id and the lowest free slot.
      S_SCAN: begin
        if (rd_valid && (rd_id == req.tmr_id) && !match_found) begin
          match_found_next = 1'b1;
          match_idx_next   = rd_idx;
        end
        if (!rd_valid && !free_found) begin
          free_found_next = 1'b1;
          free_idx_next   = rd_idx;
        end
        if (idx == LAST_IDX) begin
          state_next = S_COMMIT;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      S_COMMIT: begin
        result_valid_next       = 1'b1;
        result_next.result_kind = RK_STATUS;
        result_next.fired_id    = req.tmr_id;
        result_next.last        = 1'b1;
        state_next              = S_IDLE;
        if (req.kind == K_KILL) begin
          wr.clr_we          = match_found;
          result_next.status = match_found ? ST_OK : ST_REJECT;
        end else if (match_found || free_found) begin
          // The freed match slot counts as free when it is lower.
          wr.clr_we          = match_found;
          wr.entry_we        = 1'b1;
          waddr              = (free_found && (!match_found || (free_idx < match_idx))) ?
                               free_idx : match_idx;
          result_next.status = ST_OK;
        end else begin
          result_next.status = ST_FULL;
        end
      end

      S_TICK_A: begin
        if ((idx == END_IDX) || (fires == FIRE_MAX)) begin
          state_next = S_TICK_END;
        end else if (rd_valid) begin
          due_load   = 1'b1;
          state_next = S_TICK_B;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      // Resynchronize or fire; a pending fire is sent once the next one shows up.
      S_TICK_B: begin
        if (due.back) begin
          wr.lf_we     = 1'b1;
          wr.last_fire = req.now_ms;
        end else if (due.due) begin
          wr.lf_we     = 1'b1;
          wr.last_fire = due.sum;
          if (pend) begin
            result_valid_next       = 1'b1;
            result_next.result_kind = RK_FIRE;
            result_next.fired_id    = pend_id;
            result_next.status      = ST_OK;
            result_next.last        = 1'b0;
          end
          pend_next    = 1'b1;
          pend_id_next = rd_id;
          fires_next   = fires + 1'b1;
        end
        idx_next   = idx + 1'b1;
        state_next = S_TICK_A;
      end

      S_TICK_END: begin
        if (pend) begin
          result_valid_next       = 1'b1;
          result_next.result_kind = RK_FIRE;
          result_next.fired_id    = pend_id;
          result_next.status      = ST_OK;
          result_next.last        = 1'b1;
        end
        pend_next  = 1'b0;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      fires        <= '0;
      match_found  <= 1'b0;
      free_found   <= 1'b0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      idx          <= idx_next;
      fires        <= fires_next;
      match_found  <= match_found_next;
      free_found   <= free_found_next;
      pend         <= pend_next;
      result_valid <= result_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req       <= req_next;
    match_idx <= match_idx_next;
    free_idx  <= free_idx_next;
    pend_id   <= pend_id_next;
    result    <= result_next;
  end

  // Minimum interval register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= MIN_INTERVAL_RST;
    end else if (cfg_we) begin
      min_interval <= cfg_data;
    end
  end

  // A status beat always ends its request.
  `PTTU_ASSERT_SAME(a_status_last, result_valid && (result.result_kind == RK_STATUS), result.last)
  // The final beat of a request leaves the unit idle.
  `PTTU_ASSERT_SAME(a_last_idle, result_valid && result.last, !busy)
  // The fire count never passes the cap.
  `PTTU_ASSERT_SAME(a_fire_cap, 1'b1, fires <= FIRE_MAX)
  // An accepted tick, set or kill keeps the unit busy in the next cycle.
  `PTTU_ASSERT_NEXT(a_accept_busy, start && !busy && (cmd.kind != K_NONE), busy)

endmodule
`default_nettype wire
